// ===== src/dhcp_reply_parser_assert.svh =====
// Assertion macros for the DHCP reply parser.
// Expects signals named clk and rst_n in the including module.
`ifndef DHCP_REPLY_PARSER_ASSERT_SVH
`define DHCP_REPLY_PARSER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DRP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dhcp_reply_parser: assertion failed");
`define DRP_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dhcp_reply_parser: reset assertion failed");
`else
`define DRP_ASSERT(lbl, prop)
`define DRP_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== src/dhcp_rp_pkg.sv =====
// Shared types and constants for the DHCP reply parser.
// No dependencies.
package dhcp_rp_pkg;

  localparam int HDR_BYTES = 240;

  localparam logic [31:0] COOKIE   = 32'h63825363;
  localparam logic [7:0]  HLEN_ETH = 8'd6;

  // header offsets
  localparam logic [7:0] OFS_HLEN     = 8'd2;
  localparam logic [7:0] OFS_XID_FST  = 8'd4;
  localparam logic [7:0] OFS_XID_LST  = 8'd7;
  localparam logic [7:0] OFS_YI_FST   = 8'd16;
  localparam logic [7:0] OFS_YI_LST   = 8'd19;
  localparam logic [7:0] OFS_MAC_FST  = 8'd28;
  localparam logic [7:0] OFS_MAC_LST  = 8'd33;
  localparam logic [7:0] OFS_CK_FST   = 8'd236;
  localparam logic [7:0] OFS_CK_LST   = 8'd239;

  // option codes
  localparam logic [7:0] OPT_PAD       = 8'd0;
  localparam logic [7:0] OPT_SUBNET    = 8'd1;
  localparam logic [7:0] OPT_ROUTER    = 8'd3;
  localparam logic [7:0] OPT_DNS       = 8'd6;
  localparam logic [7:0] OPT_LEASE     = 8'd51;
  localparam logic [7:0] OPT_MSG_TYPE  = 8'd53;
  localparam logic [7:0] OPT_SERVER_ID = 8'd54;
  localparam logic [7:0] OPT_END       = 8'd255;

  localparam logic [7:0] MSG_OFFER = 8'd2;
  localparam logic [7:0] MSG_ACK   = 8'd5;

  // found flag bits
  localparam int F_TYPE   = 0;
  localparam int F_SRVID  = 1;
  localparam int F_MASK   = 2;
  localparam int F_ROUTER = 3;
  localparam int F_DNS    = 4;
  localparam int F_LEASE  = 5;

  localparam logic [5:0] NEED_OFFER = 6'b000010;
  localparam logic [5:0] NEED_ACK   = 6'b111100;

  // configuration register indexes
  localparam logic [1:0] CFG_XID = 2'd0;
  localparam logic [1:0] CFG_MAC = 2'd1;
  localparam logic [1:0] CFG_ACK = 2'd2;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_HDR_BAD     = 2'd1,
    ST_BAD_TYPE    = 2'd2,
    ST_OPT_MISSING = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_CODE  = 2'd0,
    PH_LEN   = 2'd1,
    PH_VALUE = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  // per-byte control from the top level to the header and option units
  typedef struct packed {
    logic step;    // byte is processed this cycle
    logic clr;     // last byte: return to packet start afterwards
    logic ovf;     // byte beyond maximum packet length
    logic hdr_en;  // byte lies in the fixed header
    logic opt_en;  // byte lies in the option area
  } byte_ctl_t;

  typedef struct packed {
    logic        bad;
    logic [31:0] yiaddr;
  } hdr_view_t;

  typedef struct packed {
    phase_t      phase;
    logic [5:0]  found;
    logic [7:0]  msg_type;
    logic [31:0] server_id;
    logic [31:0] subnet_mask;
    logic [31:0] router_ip;
    logic [31:0] dns_primary;
    logic [31:0] dns_secondary;
    logic [31:0] lease_seconds;
  } opt_view_t;

endpackage

// ===== src/dhcp_rp_hdr.sv =====
// Fixed header checker: hlen, xid, chaddr and cookie compare, yiaddr capture.
// Depends on dhcp_rp_pkg.
module dhcp_rp_hdr (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dhcp_rp_pkg::byte_ctl_t ctl,
  input  logic [7:0]            pos,
  input  logic [7:0]            rx_byte,
  input  logic [31:0]           xid,
  input  logic [47:0]           mac,
  output dhcp_rp_pkg::hdr_view_t view
);
  import dhcp_rp_pkg::*;

  logic        bad_r, bad_nxt;
  logic [31:0] yiaddr_r, yiaddr_nxt;
  logic [7:0]  want;
  logic        check;
  logic [2:0]  mac_idx;

  assign mac_idx = 3'(OFS_MAC_LST - pos);

  always_comb begin
    want  = '0;
    check = 1'b0;
    priority if (pos == OFS_HLEN) begin
      check = 1'b1;
      want  = HLEN_ETH;
    end else if (pos >= OFS_XID_FST && pos <= OFS_XID_LST) begin
      check = 1'b1;
      want  = 8'(xid >> {~pos[1:0], 3'b000});
    end else if (pos >= OFS_MAC_FST && pos <= OFS_MAC_LST) begin
      check = 1'b1;
      want  = 8'(mac >> {mac_idx, 3'b000});
    end else if (pos >= OFS_CK_FST && pos <= OFS_CK_LST) begin
      check = 1'b1;
      want  = 8'(COOKIE >> {~pos[1:0], 3'b000});
    end else begin
      check = 1'b0;
    end
  end

  always_comb begin
    bad_nxt    = bad_r;
    yiaddr_nxt = yiaddr_r;
    if (ctl.step) begin
      if (ctl.ovf || (ctl.hdr_en && check && rx_byte != want)) begin
        bad_nxt = 1'b1;
      end
      if (ctl.hdr_en && pos >= OFS_YI_FST && pos <= OFS_YI_LST) begin
        yiaddr_nxt = {yiaddr_r[23:0], rx_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bad_r <= 1'b0;
    end else if (ctl.clr) begin
      bad_r <= 1'b0;
    end else begin
      bad_r <= bad_nxt;
    end
  end

  // yiaddr is fully rewritten by every packet that reaches the options
  always_ff @(posedge clk) begin
    yiaddr_r <= yiaddr_nxt;
  end

  assign view = '{bad: bad_nxt, yiaddr: yiaddr_nxt};

endmodule

// ===== src/dhcp_rp_opt.sv =====
// Option walker: TLV phase tracking, value collection and first-occurrence capture.
// Depends on dhcp_rp_pkg.
module dhcp_rp_opt (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dhcp_rp_pkg::byte_ctl_t ctl,
  input  logic [7:0]            rx_byte,
  output dhcp_rp_pkg::opt_view_t view
);
  import dhcp_rp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [63:0] shift_r, shift_nxt;
  logic [5:0]  found_r, found_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [31:0] srv_r, srv_nxt;
  logic [31:0] mask_r, mask_nxt;
  logic [31:0] rtr_r, rtr_nxt;
  logic [31:0] dns1_r, dns1_nxt;
  logic [31:0] dns2_r, dns2_nxt;
  logic [31:0] lease_r, lease_nxt;
  logic        fin;
  logic        long_val;
  logic [31:0] hi_w, lo_w;

  // walk one option byte
  always_comb begin
    phase_nxt = phase_r;
    code_nxt  = code_r;
    left_nxt  = left_r;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    fin       = 1'b0;
    if (ctl.step && ctl.opt_en) begin
      unique case (phase_r)
        PH_CODE: begin
          if (rx_byte == OPT_END) begin
            phase_nxt = PH_DONE;
          end else if (rx_byte != OPT_PAD) begin
            code_nxt  = rx_byte;
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          left_nxt  = rx_byte;
          cnt_nxt   = '0;
          shift_nxt = '0;
          phase_nxt = (rx_byte == 8'd0) ? PH_CODE : PH_VALUE;
        end
        PH_VALUE: begin
          // keep the first eight value bytes, first byte most significant
          if (!cnt_r[3]) begin
            for (int k = 0; k < 8; k++) begin
              if (cnt_r[2:0] == 3'(k)) begin
                shift_nxt[63 - 8*k -: 8] = rx_byte;
              end
            end
            cnt_nxt = cnt_r + 4'd1;
          end
          left_nxt = left_r - 8'd1;
          if (left_r == 8'd1) begin
            fin       = 1'b1;
            phase_nxt = PH_CODE;
          end
        end
        PH_DONE: begin
          phase_nxt = PH_DONE;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  assign hi_w     = shift_nxt[63:32];
  assign lo_w     = shift_nxt[31:0];
  assign long_val = (cnt_nxt >= 4'd4);

  // capture the first usable occurrence of each option
  always_comb begin
    found_nxt = found_r;
    type_nxt  = type_r;
    srv_nxt   = srv_r;
    mask_nxt  = mask_r;
    rtr_nxt   = rtr_r;
    dns1_nxt  = dns1_r;
    dns2_nxt  = dns2_r;
    lease_nxt = lease_r;
    if (fin) begin
      case (code_r)
        OPT_MSG_TYPE: begin
          if (!found_r[F_TYPE]) begin
            type_nxt          = hi_w[31:24];
            found_nxt[F_TYPE] = 1'b1;
          end
        end
        OPT_SERVER_ID: begin
          if (!found_r[F_SRVID] && long_val) begin
            srv_nxt            = hi_w;
            found_nxt[F_SRVID] = 1'b1;
          end
        end
        OPT_SUBNET: begin
          if (!found_r[F_MASK] && long_val) begin
            mask_nxt          = hi_w;
            found_nxt[F_MASK] = 1'b1;
          end
        end
        OPT_ROUTER: begin
          if (!found_r[F_ROUTER] && long_val) begin
            rtr_nxt             = hi_w;
            found_nxt[F_ROUTER] = 1'b1;
          end
        end
        OPT_DNS: begin
          if (!found_r[F_DNS] && long_val) begin
            dns1_nxt         = hi_w;
            dns2_nxt         = cnt_nxt[3] ? lo_w : 32'd0;
            found_nxt[F_DNS] = 1'b1;
          end
        end
        OPT_LEASE: begin
          if (!found_r[F_LEASE] && long_val) begin
            lease_nxt          = hi_w;
            found_nxt[F_LEASE] = 1'b1;
          end
        end
        default: begin
          found_nxt = found_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      phase_r <= PH_CODE;
      code_r  <= '0;
      left_r  <= '0;
      cnt_r   <= '0;
      shift_r <= '0;
      found_r <= '0;
      type_r  <= '0;
      srv_r   <= '0;
      mask_r  <= '0;
      rtr_r   <= '0;
      dns1_r  <= '0;
      dns2_r  <= '0;
      lease_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      code_r  <= code_nxt;
      left_r  <= left_nxt;
      cnt_r   <= cnt_nxt;
      shift_r <= shift_nxt;
      found_r <= found_nxt;
      type_r  <= type_nxt;
      srv_r   <= srv_nxt;
      mask_r  <= mask_nxt;
      rtr_r   <= rtr_nxt;
      dns1_r  <= dns1_nxt;
      dns2_r  <= dns2_nxt;
      lease_r <= lease_nxt;
    end
  end

  assign view = '{
    phase:         phase_nxt,
    found:         found_nxt,
    msg_type:      type_nxt,
    server_id:     srv_nxt,
    subnet_mask:   mask_nxt,
    router_ip:     rtr_nxt,
    dns_primary:   dns1_nxt,
    dns_secondary: dns2_nxt,
    lease_seconds: lease_nxt
  };

endmodule

// ===== src/dhcp_reply_parser.sv =====
// DHCP reply parser top level: input register, position counter, verdict, result register.
// Throughput one byte per cycle; each accepted byte is held in the input register, and
// the verdict is computed from it and registered in the result register for the output.
// The byte path stalls only while the last byte waits on a full result register.
// Synchronous active-low reset clears configuration, packet state and both valids.
// Depends on dhcp_rp_pkg, dhcp_rp_hdr, dhcp_rp_opt and dhcp_reply_parser_assert.svh.
`include "dhcp_reply_parser_assert.svh"
module dhcp_reply_parser #(
  parameter int MAX_PACKET_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_assigned_ip,
  output logic [31:0] out_server_id,
  output logic [31:0] out_subnet_mask,
  output logic [31:0] out_router_ip,
  output logic [31:0] out_dns_primary,
  output logic [31:0] out_dns_secondary,
  output logic [31:0] out_lease_seconds,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  import dhcp_rp_pkg::*;

  localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);

  // configuration
  logic [31:0] xid_r;
  logic [47:0] mac_r;
  logic        ack_r;

  // input stage
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       proceed;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             ovf;
  logic             in_hdr;
  byte_ctl_t        ctl;
  hdr_view_t        hdr_v;
  opt_view_t        opt_v;

  status_t    status;
  logic [7:0] want_type;
  logic [5:0] need;

  // result register
  logic        out_valid_r;
  status_t     out_status_r;
  logic [31:0] out_assigned_ip_r;
  logic [31:0] out_server_id_r;
  logic [31:0] out_subnet_mask_r;
  logic [31:0] out_router_ip_r;
  logic [31:0] out_dns_primary_r;
  logic [31:0] out_dns_secondary_r;
  logic [31:0] out_lease_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xid_r <= '0;
      mac_r <= '0;
      ack_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_XID: xid_r <= cfg_data[31:0];
        CFG_MAC: mac_r <= cfg_data;
        CFG_ACK: ack_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // the last byte may only advance when the result register can take its verdict
  assign proceed  = in_valid_r && (!in_last_r || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || proceed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
      in_last_r <= in_last_byte;
    end
  end

  assign ovf     = (pos_r >= POS_W'(MAX_PACKET_BYTES));
  assign in_hdr  = (pos_r < POS_W'(HDR_BYTES));
  assign pos_nxt = ovf ? pos_r : pos_r + POS_W'(1);

  assign ctl = '{
    step:   proceed,
    clr:    proceed && in_last_r,
    ovf:    ovf,
    hdr_en: !ovf && in_hdr,
    opt_en: !ovf && !in_hdr
  };

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (ctl.clr) begin
      pos_r <= '0;
    end else if (ctl.step) begin
      pos_r <= pos_nxt;
    end
  end

  dhcp_rp_hdr u_hdr (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .pos     (pos_r[7:0]),
    .rx_byte (in_byte_r),
    .xid     (xid_r),
    .mac     (mac_r),
    .view    (hdr_v)
  );

  dhcp_rp_opt u_opt (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rx_byte (in_byte_r),
    .view    (opt_v)
  );

  assign want_type = ack_r ? MSG_ACK : MSG_OFFER;
  assign need      = ack_r ? NEED_ACK : NEED_OFFER;

  always_comb begin
    priority if (hdr_v.bad || pos_nxt < POS_W'(HDR_BYTES) ||
                 opt_v.phase == PH_LEN || opt_v.phase == PH_VALUE) begin
      status = ST_HDR_BAD;
    end else if (!opt_v.found[F_TYPE] || opt_v.msg_type != want_type) begin
      status = ST_BAD_TYPE;
    end else if ((opt_v.found & need) != need) begin
      status = ST_OPT_MISSING;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.clr) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      out_status_r <= status;
      if (status == ST_HDR_BAD) begin
        out_assigned_ip_r   <= '0;
        out_server_id_r     <= '0;
        out_subnet_mask_r   <= '0;
        out_router_ip_r     <= '0;
        out_dns_primary_r   <= '0;
        out_dns_secondary_r <= '0;
        out_lease_r         <= '0;
      end else begin
        out_assigned_ip_r   <= hdr_v.yiaddr;
        out_server_id_r     <= opt_v.server_id;
        out_subnet_mask_r   <= opt_v.subnet_mask;
        out_router_ip_r     <= opt_v.router_ip;
        out_dns_primary_r   <= opt_v.dns_primary;
        out_dns_secondary_r <= opt_v.dns_secondary;
        out_lease_r         <= opt_v.lease_seconds;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_assigned_ip   = out_assigned_ip_r;
  assign out_server_id     = out_server_id_r;
  assign out_subnet_mask   = out_subnet_mask_r;
  assign out_router_ip     = out_router_ip_r;
  assign out_dns_primary   = out_dns_primary_r;
  assign out_dns_secondary = out_dns_secondary_r;
  assign out_lease_seconds = out_lease_r;

  `DRP_ASSERT(a_pos_bound, pos_r <= POS_W'(MAX_PACKET_BYTES))
  `DRP_ASSERT(a_pos_restart, proceed && in_last_r |=> pos_r == '0)
  `DRP_ASSERT(a_bad_zero, out_valid_r && out_status_r == ST_HDR_BAD |-> out_assigned_ip_r == '0 && out_server_id_r == '0 && out_lease_r == '0)
  `DRP_ASSERT_RST(a_rst_idle, !rst_n |=> !out_valid_r && !in_valid_r)

endmodule
